[rtl/rlv_pkg.sv]
// Shared types and constants of the RMS level meter that maps a frame level to a velocity.
// Holds the controller and log2 unit state types, register codes and fixed-point constants.
// No dependencies; every other file of the block imports this package.
package rlv_pkg;

  // Digit size of every serial multiplier in the block.
  localparam int DIGIT_W = 4;

  // Log2 results: 6-bit integer part (MSB index up to 63), 16 fraction bits.
  localparam int LOG_FRAC_W = 16;
  localparam int LOG_INT_W  = 6;
  localparam int LOG_W      = LOG_INT_W + LOG_FRAC_W;

  // Configuration registers.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_BOUND_A = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BOUND_B = 2'd1;

  // Levels and bounds in 1/256 dB.
  localparam int DB_W = 16;
  localparam logic signed [DB_W-1:0] BOUND_A_RESET = -16'sd10240;
  localparam logic signed [DB_W-1:0] BOUND_B_RESET = 16'sd0;
  localparam logic signed [DB_W-1:0] LEVEL_FLOOR   = -16'sd25600;
  localparam logic signed [DB_W-1:0] LEVEL_TOP     = 16'sd0;

  // Velocity.
  localparam int VEL_W = 7;
  localparam logic [VEL_W-1:0] VEL_MAX  = 7'd127;
  localparam logic [VEL_W-1:0] VEL_ZERO = 7'd0;

  // Log difference and its scaling by 256*10*log10(2) in Q16.
  localparam int DIFF_W        = 24;
  localparam int MAG_W         = 23;
  localparam int K_W           = 28;
  localparam int K_DIGITS      = K_W / DIGIT_W;
  localparam logic [K_W-1:0] DB_PER_LOG2_Q16 = 28'd50504453;
  localparam int SCALE_ACC_W   = 50;
  localparam int SCALE_SHIFT   = 32;
  localparam int RND_W         = SCALE_ACC_W - SCALE_SHIFT;
  localparam logic [SCALE_ACC_W-1:0] SCALE_ROUND = SCALE_ACC_W'(1) << (SCALE_SHIFT - 1);
  localparam logic [RND_W-1:0] FLOOR_MAG = 18'd25600;

  // Velocity division remainder width.
  localparam int REM_W = 24;

  // Frame controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_CLOSE,
    ST_LOG_SUM,
    ST_LOG_CNT,
    ST_SCALE,
    ST_VEL,
    ST_DIVIDE,
    ST_EMIT
  } rlv_state_t;

  // Log2 unit states.
  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQR
  } lg_state_t;

  // Result of the log2 unit: one-cycle done strobe and the Q16 value.
  typedef struct packed {
    logic             done;
    logic [LOG_W-1:0] value;
  } log_res_t;

endpackage

[rtl/rms_level_to_velocity.sv]
// Frame RMS level meter: sums squared samples, gives the frame level in 1/256 dB and a velocity.
// Top level; instantiates rlv_log2 and depends on rlv_pkg.
//
// Usage:
// - Sample channel (sample_valid/sample_stall): one beat per audio sample; last_sample closes
//   the frame. A frame also closes on the sample that brings the count to MAX_FRAME.
// - Result channel (result_valid/result_stall): one beat per frame with velocity and level_db.
// - Configuration channel (cfg_valid/cfg_ready): always ready; index 0 writes bound A,
//   index 1 bound B, in 1/256 dB. Other indexes are ignored. Write only while idle.
// Squaring: each sample is squared by a 4-bit digit multiplier, digit by digit; the next
//   sample is taken in the cycle of the last digit, not before.
// Frame end: the log2 unit takes the sum and then the count; it normalizes each operand
//   by one-bit shifts (up to 63) and then runs its serial squarer, 8 digit steps for each
//   of 16 fraction bits. Scaling and division follow as needed. No samples are taken meanwhile.
// The result sits in an output register; if the receiver stalls, the next frame still
//   accumulates and waits only at its own end until the register is taken.
// Reset clears the accumulator, the sample count, the output valid and the bounds to
//   -40 dB and 0 dB.
module rms_level_to_velocity #(
  parameter int MAX_FRAME   = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]         sample,
  input  logic                                  last_sample,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic [rlv_pkg::VEL_W-1:0]             velocity,
  output logic signed [rlv_pkg::DB_W-1:0]       level_db,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rlv_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [rlv_pkg::DB_W-1:0]              cfg_data
);
  import rlv_pkg::*;

  localparam int CNT_W     = $clog2(MAX_FRAME + 1);
  localparam int EXACT_W   = 2 * SAMPLE_BITS - 2 + CNT_W;
  localparam int SUM_W     = (EXACT_W > 64) ? 64 : EXACT_W;
  localparam int SQ_DIGITS = (SAMPLE_BITS + DIGIT_W - 1) / DIGIT_W;
  localparam int MPL_W     = SQ_DIGITS * DIGIT_W;
  localparam int MCD_W     = SAMPLE_BITS + DIGIT_W * (SQ_DIGITS - 1);
  localparam int PART_W    = MCD_W + DIGIT_W;
  localparam int SQ_CNT_W  = $clog2(SQ_DIGITS);
  localparam int SC_MCD_W  = MAG_W + DIGIT_W * (K_DIGITS - 1);
  localparam int SC_PART_W = SC_MCD_W + DIGIT_W;
  localparam int SC_CNT_W  = $clog2(K_DIGITS);
  localparam int DIV_CNT_W = $clog2(VEL_W);
  localparam logic [CNT_W-1:0]  MAX_COUNT  = CNT_W'(MAX_FRAME);
  localparam logic [DIFF_W-1:0] LOG_OFFSET = DIFF_W'((2 * SAMPLE_BITS - 2) * (1 << LOG_FRAC_W));

  rlv_state_t                state, state_next;

  // Accumulator state and configuration.
  logic [SUM_W-1:0]          square_sum;
  logic [CNT_W-1:0]          sample_count;
  logic                      close_q;
  logic signed [DB_W-1:0]    bound_a;
  logic signed [DB_W-1:0]    bound_b;

  // Sample squarer.
  logic [MCD_W-1:0]          sq_mcand;
  logic [MPL_W-1:0]          sq_mplier;
  logic [SQ_CNT_W-1:0]       sq_cnt;
  logic [SAMPLE_BITS-1:0]    sample_u;
  logic [SAMPLE_BITS-1:0]    mag;
  logic [PART_W-1:0]         sq_part;
  logic [SUM_W:0]            sum_add;
  logic [SUM_W-1:0]          sum_sat;
  logic [CNT_W-1:0]          count_inc;
  logic                      close_in;
  logic                      sq_last;
  logic                      accept;

  // Log stage.
  logic                      log_start;
  logic [SUM_W-1:0]          log_operand;
  log_res_t                  log_res;
  logic [LOG_W-1:0]          log_sum;
  logic [DIFF_W-1:0]         diff;
  logic [DIFF_W-1:0]         diff_mag;
  logic                      diff_neg;
  logic                      sum_zero;

  // dB scaling.
  logic [SC_MCD_W-1:0]       sc_mcand;
  logic [K_W-1:0]            sc_k;
  logic [SCALE_ACC_W-1:0]    sc_acc;
  logic [SC_CNT_W-1:0]       sc_cnt;
  logic [SC_PART_W-1:0]      sc_prod;
  logic [SCALE_ACC_W-1:0]    sc_sum;
  logic [RND_W-1:0]          rnd;
  logic                      k_last;

  // Velocity mapping and division.
  logic signed [DB_W-1:0]    level_r;
  logic [VEL_W-1:0]          vel_r;
  logic signed [DB_W-1:0]    lo;
  logic signed [DB_W-1:0]    hi;
  logic signed [DB_W:0]      num;
  logic [DB_W:0]             den;
  logic                      bounds_eq;
  logic                      num_le0;
  logic                      num_ge_den;
  logic                      need_div;
  logic [VEL_W-1:0]          vel_direct;
  logic [REM_W-1:0]          rem;
  logic [REM_W-1:0]          dsr;
  logic [REM_W-1:0]          rem_init;
  logic [REM_W-1:0]          num_ext;
  logic [DIV_CNT_W-1:0]      div_cnt;
  logic                      div_last;
  logic                      div_fit;
  logic                      emit_ok;

  // Square of the sample magnitude, one digit of the multiplier per cycle.
  assign sample_u  = sample;
  assign mag       = sample_u[SAMPLE_BITS-1] ? (~sample_u + 1'b1) : sample_u;
  assign sq_part   = PART_W'(sq_mcand) * PART_W'(sq_mplier[DIGIT_W-1:0]);
  assign sum_add   = (SUM_W+1)'(square_sum) + (SUM_W+1)'(SUM_W'(sq_part));
  assign sum_sat   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign sq_last   = (sq_cnt == SQ_CNT_W'(SQ_DIGITS - 1));
  assign count_inc = sample_count + 1'b1;
  assign close_in  = last_sample || (count_inc == MAX_COUNT);
  assign accept    = sample_valid && !sample_stall;
  assign sum_zero  = (square_sum == '0);

  // Level exponent: log2(sum) - log2(count) - 2*(SAMPLE_BITS-1), Q16.
  assign diff     = DIFF_W'(log_sum) - DIFF_W'(log_res.value) - LOG_OFFSET;
  assign diff_neg = diff[DIFF_W-1];
  assign diff_mag = ~diff + 1'b1;

  // Magnitude times the dB constant, one constant digit per cycle.
  assign sc_prod = SC_PART_W'(sc_mcand) * SC_PART_W'(sc_k[DIGIT_W-1:0]);
  assign sc_sum  = sc_acc + SCALE_ACC_W'(sc_prod);
  assign rnd     = sc_sum[SCALE_ACC_W-1:SCALE_SHIFT];
  assign k_last  = (sc_cnt == SC_CNT_W'(K_DIGITS - 1));

  // Ordered bounds and the position of the level between them.
  assign lo         = (bound_a < bound_b) ? bound_a : bound_b;
  assign hi         = (bound_a < bound_b) ? bound_b : bound_a;
  assign num        = $signed({level_r[DB_W-1], level_r}) - $signed({lo[DB_W-1], lo});
  assign den        = {hi[DB_W-1], hi} - {lo[DB_W-1], lo};
  assign bounds_eq  = (den == '0);
  assign num_le0    = num[DB_W] || (num == '0);
  assign num_ge_den = !num[DB_W] && (num >= $signed(den));
  assign need_div   = !bounds_eq && !num_le0 && !num_ge_den;

  always_comb begin
    if (bounds_eq) begin
      vel_direct = (level_r >= lo) ? VEL_MAX : VEL_ZERO;
    end else if (num_le0) begin
      vel_direct = VEL_ZERO;
    end else begin
      vel_direct = VEL_MAX;
    end
  end

  // Dividend num*254 + den over divisor 2*den, quotient below 128.
  assign num_ext  = REM_W'(num[DB_W-1:0]);
  assign rem_init = (num_ext << 8) - (num_ext << 1) + REM_W'(den);
  assign div_fit  = (rem >= dsr);
  assign div_last = (div_cnt == DIV_CNT_W'(VEL_W - 1));

  // Shared log2 unit: first the sum, then the count.
  rlv_log2 #(
    .IN_W (SUM_W)
  ) u_log2 (
    .clk     (clk),
    .rst     (rst),
    .start   (log_start),
    .operand (log_operand),
    .res     (log_res)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (sq_last) begin
          if (close_q) begin
            state_next = ST_CLOSE;
          end else if (accept) begin
            state_next = ST_SQUARE;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_CLOSE: begin
        state_next = sum_zero ? ST_VEL : ST_LOG_SUM;
      end
      ST_LOG_SUM: begin
        if (log_res.done) state_next = ST_LOG_CNT;
      end
      ST_LOG_CNT: begin
        if (log_res.done) state_next = diff_neg ? ST_SCALE : ST_VEL;
      end
      ST_SCALE: begin
        if (k_last) state_next = ST_VEL;
      end
      ST_VEL: begin
        state_next = need_div ? ST_DIVIDE : ST_EMIT;
      end
      ST_DIVIDE: begin
        if (div_last) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_ok) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and log unit controls.
  always_comb begin
    sample_stall = !((state == ST_IDLE) || ((state == ST_SQUARE) && sq_last && !close_q));
    log_start    = ((state == ST_CLOSE) && !sum_zero) || ((state == ST_LOG_SUM) && log_res.done);
    log_operand  = (state == ST_CLOSE) ? square_sum : SUM_W'(sample_count);
    emit_ok      = !result_valid || !result_stall;
    cfg_ready    = 1'b1;
  end

  // Control state, accumulator and sample count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      square_sum   <= '0;
      sample_count <= '0;
      close_q      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_SQUARE) begin
        square_sum <= sum_sat;
      end
      if (accept) begin
        sample_count <= count_inc;
        close_q      <= close_in;
      end
      if ((state == ST_EMIT) && emit_ok) begin
        square_sum   <= '0;
        sample_count <= '0;
        close_q      <= 1'b0;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bound_a <= BOUND_A_RESET;
      bound_b <= BOUND_B_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BOUND_A: bound_a <= cfg_data;
        REG_BOUND_B: bound_b <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sample squarer digits.
  always_ff @(posedge clk) begin
    if (accept) begin
      sq_mcand  <= MCD_W'(mag);
      sq_mplier <= MPL_W'(mag);
      sq_cnt    <= '0;
    end else if (state == ST_SQUARE) begin
      sq_mcand  <= sq_mcand << DIGIT_W;
      sq_mplier <= sq_mplier >> DIGIT_W;
      sq_cnt    <= sq_cnt + 1'b1;
    end
  end

  // Frame end datapath: logs, scaling, velocity division.
  always_ff @(posedge clk) begin
    case (state)
      ST_CLOSE: begin
        if (sum_zero) level_r <= LEVEL_FLOOR;
      end
      ST_LOG_SUM: begin
        if (log_res.done) log_sum <= log_res.value;
      end
      ST_LOG_CNT: begin
        if (log_res.done) begin
          if (diff_neg) begin
            sc_mcand <= SC_MCD_W'(diff_mag[MAG_W-1:0]);
            sc_k     <= DB_PER_LOG2_Q16;
            sc_acc   <= SCALE_ROUND;
            sc_cnt   <= '0;
          end else begin
            level_r <= LEVEL_TOP;
          end
        end
      end
      ST_SCALE: begin
        sc_acc   <= sc_sum;
        sc_mcand <= sc_mcand << DIGIT_W;
        sc_k     <= sc_k >> DIGIT_W;
        sc_cnt   <= sc_cnt + 1'b1;
        if (k_last) begin
          // Round half away from zero happened through the preset half; clamp at -100 dB.
          level_r <= (rnd >= FLOOR_MAG) ? LEVEL_FLOOR : (DB_W'(0) - DB_W'(rnd));
        end
      end
      ST_VEL: begin
        if (need_div) begin
          vel_r   <= VEL_ZERO;
          rem     <= rem_init;
          dsr     <= REM_W'(den) << VEL_W;
          div_cnt <= '0;
        end else begin
          vel_r <= vel_direct;
        end
      end
      ST_DIVIDE: begin
        // Restoring division, one quotient bit per cycle.
        if (div_fit) rem <= rem - dsr;
        vel_r   <= {vel_r[VEL_W-2:0], div_fit};
        dsr     <= dsr >> 1;
        div_cnt <= div_cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == ST_EMIT) && emit_ok) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && emit_ok) begin
      velocity <= vel_r;
      level_db <= level_r;
    end
  end

  // The reported level always lies between -100 dB and 0 dB.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((level_db <= LEVEL_TOP) && (level_db >= LEVEL_FLOOR)))
    else $error("level_db out of range");

  // The frame never holds more than MAX_FRAME samples.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= MAX_COUNT)
    else $error("sample count beyond MAX_FRAME");

  // Handing a frame to the output register clears the accumulator.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EMIT) && emit_ok) |=> ((square_sum == '0) && (sample_count == '0)))
    else $error("accumulator not cleared after a frame");

  // The log unit only finishes while the controller waits for it.
  a_log_done: assert property (@(posedge clk) disable iff (rst)
    log_res.done |-> ((state == ST_LOG_SUM) || (state == ST_LOG_CNT)))
    else $error("log2 result arrived outside a log state");

endmodule

[rtl/rlv_log2.sv]
// Serial log2 unit: returns log2 of a positive operand in Q16.
// Normalizes one bit per cycle, then squares the Q31 mantissa 16 times with a 4-bit digit multiplier.
// Depends on rlv_pkg.
module rlv_log2 #(
  parameter int IN_W = 47
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IN_W-1:0]   operand,
  output rlv_pkg::log_res_t res
);
  import rlv_pkg::*;

  localparam int NW        = (IN_W > 32) ? IN_W : 32;
  localparam int IDX_W     = $clog2(NW);
  localparam int MANT_W    = 32;
  localparam int DIG_STEPS = MANT_W / DIGIT_W;
  localparam int DCNT_W    = $clog2(DIG_STEPS);
  localparam int ITER_W    = $clog2(LOG_FRAC_W);
  localparam int PROD_W    = MANT_W + DIGIT_W;

  lg_state_t              state, state_next;
  logic [NW-1:0]          norm;
  logic [IDX_W-1:0]       msb_idx;
  logic [MANT_W-1:0]      mcand;
  logic [MANT_W-1:0]      mplier;
  logic [MANT_W:0]        acc;
  logic [DCNT_W-1:0]      dig_cnt;
  logic [ITER_W-1:0]      iter;
  logic [LOG_FRAC_W-1:0]  frac;
  logic                   done;

  logic [PROD_W-1:0]      prod;
  logic [PROD_W:0]        step_sum;
  logic [MANT_W:0]        hi;
  logic [MANT_W-1:0]      m_next;
  logic                   last_dig;
  logic                   last_iter;

  // One digit of the mantissa square per cycle; the low nibble leaves as the sum shifts right.
  assign prod      = PROD_W'(mcand) * PROD_W'(mplier[DIGIT_W-1:0]);
  assign step_sum  = (PROD_W+1)'(acc) + (PROD_W+1)'(prod);
  assign hi        = step_sum[PROD_W:DIGIT_W];
  assign last_dig  = (dig_cnt == DCNT_W'(DIG_STEPS - 1));
  assign last_iter = (iter == '0);

  // After the last digit hi is the square over 2^32; a set top bit means the square reached 2.
  assign m_next = hi[MANT_W-1] ? hi[MANT_W-1:0] : {hi[MANT_W-2:0], step_sum[DIGIT_W-1]};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      LG_IDLE: begin
        if (start) state_next = LG_NORM;
      end
      LG_NORM: begin
        if (norm[NW-1]) state_next = LG_SQR;
      end
      LG_SQR: begin
        if (last_dig && last_iter) state_next = LG_IDLE;
      end
      default: state_next = LG_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    res.done  = done;
    res.value = {LOG_INT_W'(msb_idx), frac};
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LG_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == LG_SQR) && last_dig && last_iter;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      LG_IDLE: begin
        if (start) begin
          norm    <= NW'(operand);
          msb_idx <= IDX_W'(NW - 1);
          frac    <= '0;
        end
      end
      LG_NORM: begin
        if (norm[NW-1]) begin
          mcand   <= norm[NW-1 -: MANT_W];
          mplier  <= norm[NW-1 -: MANT_W];
          acc     <= '0;
          dig_cnt <= '0;
          iter    <= ITER_W'(LOG_FRAC_W - 1);
        end else begin
          norm    <= norm << 1;
          msb_idx <= msb_idx - 1'b1;
        end
      end
      LG_SQR: begin
        if (last_dig) begin
          mcand      <= m_next;
          mplier     <= m_next;
          acc        <= '0;
          dig_cnt    <= '0;
          frac[iter] <= hi[MANT_W-1];
          iter       <= iter - 1'b1;
        end else begin
          acc     <= hi;
          mplier  <= mplier >> DIGIT_W;
          dig_cnt <= dig_cnt + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
